### hdl/tcc_pkg.sv
// Shared types and helpers for the toroidal circle collision test.
`timescale 1ns / 1ps

package tcc_pkg;

    // Which wrapped offset an axis picked
    typedef enum logic [1:0] {
        CAND_DIRECT,
        CAND_MINUS,
        CAND_PLUS
    } cand_sel_t;

    // Result flags handed from the distance evaluator to the result register
    typedef struct packed {
        logic colliding;
        logic contains;
    } tcc_flags_t;

    // First candidate of minimal magnitude, scanned direct, minus, plus
    function automatic cand_sel_t pick_first_min(
        input logic m1_lt_m0,
        input logic m2_lt_m0,
        input logic m2_lt_m1
    );
        cand_sel_t sel;
        if (m1_lt_m0)
        begin
            sel = m2_lt_m1 ? CAND_PLUS : CAND_MINUS;
        end
        else
        begin
            sel = m2_lt_m0 ? CAND_PLUS : CAND_DIRECT;
        end
        return sel;
    endfunction

endpackage

### hdl/tcc_axis_select.sv
// Minimum-image offset selection for one axis.
`timescale 1ns / 1ps

module tcc_axis_select
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic [COORD_BITS-1:0]        self_pos,
    input  logic [COORD_BITS-1:0]        other_pos,
    input  logic [COORD_BITS-1:0]        world_size,
    output logic signed [COORD_BITS:0]   offset,
    output logic [COORD_BITS-1:0]        magnitude
);

    localparam int CW = COORD_BITS + 2;

    logic signed [CW-1:0]     diff;
    logic signed [CW-1:0]     diff_minus;
    logic signed [CW-1:0]     diff_plus;
    logic signed [CW-1:0]     world_ext;
    logic [COORD_BITS:0]      mag_direct;
    logic [COORD_BITS:0]      mag_minus;
    logic [COORD_BITS:0]      mag_plus;
    logic [COORD_BITS:0]      mag_pick;
    logic signed [CW-1:0]     chosen;
    cand_sel_t                sel;

    function automatic logic [COORD_BITS:0] abs_val(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] a;
        a = v[CW-1] ? -v : v;
        return a[COORD_BITS:0];
    endfunction

    assign world_ext  = $signed({2'b00, world_size});
    assign diff       = $signed({2'b00, other_pos}) - $signed({2'b00, self_pos});
    assign diff_minus = diff - world_ext;
    assign diff_plus  = diff + world_ext;

    assign mag_direct = abs_val(diff);
    assign mag_minus  = abs_val(diff_minus);
    assign mag_plus   = abs_val(diff_plus);

    assign sel = pick_first_min(mag_minus < mag_direct,
                                mag_plus  < mag_direct,
                                mag_plus  < mag_minus);

    always_comb
    begin
        case (sel)
            CAND_DIRECT:
            begin
                chosen   = diff;
                mag_pick = mag_direct;
            end
            CAND_MINUS:
            begin
                chosen   = diff_minus;
                mag_pick = mag_minus;
            end
            CAND_PLUS:
            begin
                chosen   = diff_plus;
                mag_pick = mag_plus;
            end
            default:
            begin
                chosen   = diff;
                mag_pick = mag_direct;
            end
        endcase
    end

    // The pick never exceeds |diff|, so both narrow safely
    assign offset    = chosen[COORD_BITS:0];
    assign magnitude = mag_pick[COORD_BITS-1:0];

endmodule

### hdl/tcc_dist_eval.sv
// Squared distance sum, saturation and radius comparisons.
`timescale 1ns / 1ps

module tcc_dist_eval
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic [2*COORD_BITS-1:0]  sq_x,
    input  logic [2*COORD_BITS-1:0]  sq_y,
    input  logic [2*COORD_BITS+1:0]  lim_sum,
    input  logic [2*COORD_BITS-1:0]  lim_diff,
    input  logic                     diff_ok,
    output logic [2*COORD_BITS-1:0]  dist_sq,
    output tcc_flags_t               flags
);

    localparam int SW = 2 * COORD_BITS;

    logic [SW:0] total;

    assign total = {1'b0, sq_x} + {1'b0, sq_y};

    // Flags use the exact sum; only the reported value saturates
    assign flags.colliding = {1'b0, total} <= lim_sum;
    assign flags.contains  = diff_ok && (total <= {1'b0, lim_diff});
    assign dist_sq         = total[SW] ? {SW{1'b1}} : total[SW-1:0];

endmodule

### hdl/toroidal_circle_collision_test.sv
// Top level: pipelined minimum-image circle collision test on a torus.
//
//   channel   signals                          direction  transfer when
//   input     in_valid, in_stall, 6 fields     in / out   in_valid && !in_stall
//   output    out_valid, out_stall, 5 fields   out / in   out_valid && !out_stall
//   config    cfg_wr_en, cfg_wr_data           in         cfg_wr_en
//
// One item per cycle while out_stall is low; an item reaches out_valid through
// four registers (input register, offset select, square multipliers, result register).
// rst_n clears all stage valids and sets world_size to all ones.
// A stage holds while the stage after it is full and stalled; in_stall rises
// only when all four stages are full and out_stall is high.
`timescale 1ns / 1ps

module toroidal_circle_collision_test
    import tcc_pkg::*;
#(
    parameter int COORD_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [COORD_BITS-1:0]         cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [COORD_BITS-1:0]         self_x,
    input  logic [COORD_BITS-1:0]         self_y,
    input  logic [COORD_BITS-1:0]         self_radius,
    input  logic [COORD_BITS-1:0]         other_x,
    input  logic [COORD_BITS-1:0]         other_y,
    input  logic [COORD_BITS-1:0]         other_radius,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS:0]    dir_x,
    output logic signed [COORD_BITS:0]    dir_y,
    output logic [2*COORD_BITS-1:0]       dist_sq,
    output logic                          colliding,
    output logic                          contains
);

    localparam int N  = COORD_BITS;
    localparam int SW = 2 * COORD_BITS;

    // control
    logic [N-1:0] world_reg;
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic free0, free1, free2, free3;

    // stage 0: input register
    logic [N-1:0] sx_reg, sy_reg, sr_reg, ox_reg, oy_reg, orad_reg;

    // stage 1: chosen offsets and radius terms
    logic signed [N:0] dx1_reg, dy1_reg;
    logic [N-1:0]      mx1_reg, my1_reg;
    logic [N:0]        rsum1_reg;
    logic [N-1:0]      rdiff1_reg;
    logic              rok1_reg;
    logic signed [N:0] dx1_next, dy1_next;
    logic [N-1:0]      mx1_next, my1_next;
    logic [N:0]        rsum1_next;
    logic [N-1:0]      rdiff1_next;
    logic              rok1_next;

    // stage 2: squares
    logic signed [N:0] dx2_reg, dy2_reg;
    logic [SW-1:0]     sqx2_reg, sqy2_reg, limd2_reg;
    logic [SW+1:0]     lims2_reg;
    logic              rok2_reg;
    logic [SW-1:0]     sqx2_next, sqy2_next, limd2_next;
    logic [SW+1:0]     lims2_next;

    // stage 3: result register
    logic signed [N:0] dx3_reg, dy3_reg;
    logic [SW-1:0]     dsq3_reg;
    tcc_flags_t        flags3_reg;
    logic [SW-1:0]     dsq3_next;
    tcc_flags_t        flags3_next;

    // pipeline flow: a stage loads when it is empty or its content moves on
    assign free3 = !v3_reg || !out_stall;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;
    assign free0 = !v0_reg || free1;

    assign in_stall = !free0;

    assign v0_next = free0 ? in_valid : v0_reg;
    assign v1_next = free1 ? v0_reg   : v1_reg;
    assign v2_next = free2 ? v1_reg   : v2_reg;
    assign v3_next = free3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            world_reg <= {N{1'b1}};
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            if (cfg_wr_en)
            begin
                world_reg <= cfg_wr_data;
            end
        end
    end

    // stage 1 logic
    tcc_axis_select #(.COORD_BITS(N)) u_sel_x (
        .self_pos   (sx_reg),
        .other_pos  (ox_reg),
        .world_size (world_reg),
        .offset     (dx1_next),
        .magnitude  (mx1_next)
    );

    tcc_axis_select #(.COORD_BITS(N)) u_sel_y (
        .self_pos   (sy_reg),
        .other_pos  (oy_reg),
        .world_size (world_reg),
        .offset     (dy1_next),
        .magnitude  (my1_next)
    );

    assign rsum1_next  = {1'b0, sr_reg} + {1'b0, orad_reg};
    assign rdiff1_next = sr_reg - orad_reg;
    assign rok1_next   = sr_reg >= orad_reg;

    // stage 2 logic: one multiplier per path
    assign sqx2_next  = {{N{1'b0}}, mx1_reg} * {{N{1'b0}}, mx1_reg};
    assign sqy2_next  = {{N{1'b0}}, my1_reg} * {{N{1'b0}}, my1_reg};
    assign lims2_next = {{(N+1){1'b0}}, rsum1_reg} * {{(N+1){1'b0}}, rsum1_reg};
    assign limd2_next = {{N{1'b0}}, rdiff1_reg} * {{N{1'b0}}, rdiff1_reg};

    // stage 3 logic
    tcc_dist_eval #(.COORD_BITS(N)) u_eval (
        .sq_x     (sqx2_reg),
        .sq_y     (sqy2_reg),
        .lim_sum  (lims2_reg),
        .lim_diff (limd2_reg),
        .diff_ok  (rok2_reg),
        .dist_sq  (dsq3_next),
        .flags    (flags3_next)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (free0 && in_valid)
        begin
            sx_reg   <= self_x;
            sy_reg   <= self_y;
            sr_reg   <= self_radius;
            ox_reg   <= other_x;
            oy_reg   <= other_y;
            orad_reg <= other_radius;
        end
        if (free1 && v0_reg)
        begin
            dx1_reg    <= dx1_next;
            dy1_reg    <= dy1_next;
            mx1_reg    <= mx1_next;
            my1_reg    <= my1_next;
            rsum1_reg  <= rsum1_next;
            rdiff1_reg <= rdiff1_next;
            rok1_reg   <= rok1_next;
        end
        if (free2 && v1_reg)
        begin
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            sqx2_reg  <= sqx2_next;
            sqy2_reg  <= sqy2_next;
            lims2_reg <= lims2_next;
            limd2_reg <= limd2_next;
            rok2_reg  <= rok1_reg;
        end
        if (free3 && v2_reg)
        begin
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
            dsq3_reg   <= dsq3_next;
            flags3_reg <= flags3_next;
        end
    end

    assign out_valid = v3_reg;
    assign dir_x     = dx3_reg;
    assign dir_y     = dy3_reg;
    assign dist_sq   = dsq3_reg;
    assign colliding = flags3_reg.colliding;
    assign contains  = flags3_reg.contains;

    // containment is a tighter bound than collision
    a_contains_collides: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!contains || colliding))
        else $error("contains set without colliding");

    // input backs up only when every stage is full and the output is stalled
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && v0_reg && v1_reg && v2_reg))
        else $error("input stalled with room in the pipeline");

    // zero distance means a zero offset and a hit
    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (dist_sq == '0)) |-> (colliding && (dir_x == '0) && (dir_y == '0)))
        else $error("zero distance with nonzero offset or no collision");

    // an empty pipeline never reports a result next cycle
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!v2_reg && !out_valid) |=> !out_valid)
        else $error("result appeared without an item behind it");

endmodule

### verif/tb_top.sv
// Testbench for the toroidal circle collision test: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_top;

    localparam int CB = 20;
    localparam longint MAXC = (64'd1 << CB) - 1;
    localparam longint SQ_ALL = (64'd1 << (2 * CB)) - 1;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 40;
    localparam int PRESSURE_BURST = 30;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES = 10;
    localparam int TIMEOUT_NS = 10_000_000;

    typedef struct packed {
        logic [CB-1:0] self_x;
        logic [CB-1:0] self_y;
        logic [CB-1:0] self_radius;
        logic [CB-1:0] other_x;
        logic [CB-1:0] other_y;
        logic [CB-1:0] other_radius;
    } query_t;

    typedef struct packed {
        logic signed [CB:0] dir_x;
        logic signed [CB:0] dir_y;
        logic [2*CB-1:0]    dist_sq;
        logic               colliding;
        logic               contains;
    } collision_t;

    typedef struct packed {
        logic [CB-1:0] world;
        query_t        q;
        logic          typed;
        collision_t    res;
    } step_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CB-1:0]        cfg_wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CB-1:0]        self_x;
    logic [CB-1:0]        self_y;
    logic [CB-1:0]        self_radius;
    logic [CB-1:0]        other_x;
    logic [CB-1:0]        other_y;
    logic [CB-1:0]        other_radius;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [CB:0]   dir_x;
    logic signed [CB:0]   dir_y;
    logic [2*CB-1:0]      dist_sq;
    logic                 colliding;
    logic                 contains;

    collision_t  pending_collisions[$];
    step_row_t   step_rows[$];
    collision_t  want_res;
    logic [CB-1:0] world_now;
    int          mismatches = 0;
    int          holds_asked = 0;
    int          holds_seen = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    toroidal_circle_collision_test #(
        .COORD_BITS(CB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .self_x(self_x),
        .self_y(self_y),
        .self_radius(self_radius),
        .other_x(other_x),
        .other_y(other_y),
        .other_radius(other_radius),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .dist_sq(dist_sq),
        .colliding(colliding),
        .contains(contains)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint sq_mag(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    // Nearest image over the nine wrapped offsets; strict compare keeps the first on a tie
    function automatic collision_t predict_collision(input query_t q, input logic [CB-1:0] w);
        longint cx[3];
        longint cy[3];
        longint bx;
        longint by;
        longint best;
        longint cand;
        longint rsum;
        longint rdiff;
        collision_t r;
        cx[0] = longint'(q.other_x) - longint'(q.self_x);
        cx[1] = cx[0] - longint'(w);
        cx[2] = cx[0] + longint'(w);
        cy[0] = longint'(q.other_y) - longint'(q.self_y);
        cy[1] = cy[0] - longint'(w);
        cy[2] = cy[0] + longint'(w);
        best = -1;
        bx = 0;
        by = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cand = sq_mag(cx[i]) + sq_mag(cy[j]);
                if (best < 0 || cand < best)
                begin
                    best = cand;
                    bx = cx[i];
                    by = cy[j];
                end
            end
        end
        rsum = longint'(q.self_radius) + longint'(q.other_radius);
        rdiff = longint'(q.self_radius) - longint'(q.other_radius);
        r.dir_x = bx[CB:0];
        r.dir_y = by[CB:0];
        // Saturate the reported square; flags use the exact value
        r.dist_sq = (best > SQ_ALL) ? SQ_ALL[2*CB-1:0] : best[2*CB-1:0];
        r.colliding = (best <= rsum * rsum);
        r.contains = (rdiff >= 0) && (best <= rdiff * rdiff);
        return r;
    endfunction

    function automatic logic [CB-1:0] rand_coord(input logic [CB-1:0] lim);
        logic [CB-1:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: c = CB'($urandom_range(0, lim));
            6, 7:             c = CB'($urandom);
            8:
            begin
                case ($urandom_range(0, 2))
                    0:       c = '0;
                    1:       c = lim;
                    default: c = MAXC[CB-1:0];
                endcase
            end
            default:          c = lim - CB'($urandom_range(0, 15));
        endcase
        return c;
    endfunction

    function automatic logic [CB-1:0] rand_radius(input logic [CB-1:0] lim);
        logic [CB-1:0] r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r = CB'($urandom_range(0, 4095));
            5, 6:          r = CB'($urandom_range(0, lim));
            7:             r = '0;
            default:       r = CB'($urandom);
        endcase
        return r;
    endfunction

    function automatic query_t rand_query(input logic [CB-1:0] w);
        query_t q;
        logic [CB-1:0] lim;
        lim = (w == 0) ? MAXC[CB-1:0] : w;
        q.self_x = rand_coord(lim);
        q.self_y = rand_coord(lim);
        // Place the other circle close by about a third of the time so overlaps occur
        if ($urandom_range(0, 2) == 0)
        begin
            q.other_x = q.self_x + CB'($urandom_range(0, 2047)) - CB'(1024);
            q.other_y = q.self_y + CB'($urandom_range(0, 2047)) - CB'(1024);
        end
        else
        begin
            q.other_x = rand_coord(lim);
            q.other_y = rand_coord(lim);
        end
        q.self_radius = rand_radius(lim);
        q.other_radius = ($urandom_range(0, 7) == 0) ? q.self_radius : rand_radius(lim);
        return q;
    endfunction

    task automatic add_row(input longint w, input longint sx, input longint sy,
                           input longint sr, input longint ox, input longint oy,
                           input longint orad, input bit typed, input longint dx,
                           input longint dy, input longint dsq, input bit col,
                           input bit con);
        step_row_t row;
        row.world = w[CB-1:0];
        row.q.self_x = sx[CB-1:0];
        row.q.self_y = sy[CB-1:0];
        row.q.self_radius = sr[CB-1:0];
        row.q.other_x = ox[CB-1:0];
        row.q.other_y = oy[CB-1:0];
        row.q.other_radius = orad[CB-1:0];
        row.typed = typed;
        row.res.dir_x = dx[CB:0];
        row.res.dir_y = dy[CB:0];
        row.res.dist_sq = dsq[2*CB-1:0];
        row.res.colliding = col;
        row.res.contains = con;
        step_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Offer one query and hold it until the transfer edge
    task automatic send_query(input query_t q, input collision_t res);
        in_valid <= 1'b1;
        self_x <= q.self_x;
        self_y <= q.self_y;
        self_radius <= q.self_radius;
        other_x <= q.other_x;
        other_y <= q.other_y;
        other_radius <= q.other_radius;
        do
        begin
            @(negedge clk);
        end
        while (in_stall);
        pending_collisions.push_back(res);
        @(posedge clk);
    endtask

    // Write the world side once the pipeline has drained
    task automatic set_world(input logic [CB-1:0] w);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_collisions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        world_now = w;
    endtask

    initial
    begin
        int n;
        int burst;
        int gap;
        logic [CB-1:0] w;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        self_x <= '0;
        self_y <= '0;
        self_radius <= '0;
        other_x <= '0;
        other_y <= '0;
        other_radius <= '0;
        world_now = MAXC[CB-1:0];

        //      world  sx    sy    sr    ox      oy    orad   typed dx  dy  dist  col con
        add_row(MAXC, 0,    0,    0,    0,      0,    0,     1, 0,  0,  0,      1, 1);
        add_row(MAXC, MAXC, MAXC, MAXC, MAXC,   MAXC, MAXC,  1, 0,  0,  0,      1, 1);
        add_row(MAXC, 0,    0,    0,    MAXC,   MAXC, 0,     1, 0,  0,  0,      1, 1);
        add_row(MAXC, MAXC, 0,    0,    0,      MAXC, 0,     1, 0,  0,  0,      1, 1);
        add_row(MAXC, 0,    0,    MAXC, 524288, 0,    MAXC,  0, 0,  0,  0,      0, 0);
        // ties between the plain and a wrapped offset keep the plain one
        add_row(100,  0,    0,    0,    50,     0,    0,     1, 50, 0,  2500,   0, 0);
        add_row(100,  50,   0,    0,    0,      0,    0,     1, -50, 0, 2500,   0, 0);
        add_row(100,  0,    50,   0,    0,      0,    0,     1, 0, -50, 2500,   0, 0);
        add_row(100,  10,   20,   0,    90,     85,   0,     0, 0,  0,  0,      0, 0);
        add_row(100,  1000, 0,    5,    0,      0,    5,     0, 0,  0,  0,      0, 0);
        // square too wide for dist_sq: saturate, flags from the exact value
        add_row(1,    0,    0,    MAXC, MAXC,   MAXC, MAXC,  1, MAXC - 1, MAXC - 1, SQ_ALL, 1, 0);
        add_row(1,    MAXC, MAXC, 0,    0,      0,    0,     0, 0,  0,  0,      0, 0);
        add_row(1,    0,    0,    MAXC, MAXC,   MAXC, 176170, 0, 0, 0,  0,      0, 0);
        // zero world side: all three offsets coincide
        add_row(0,    10,   0,    9,    3,      5,    0,     1, -7, 5,  74,     1, 1);
        add_row(0,    MAXC, 0,    0,    0,      MAXC, 0,     0, 0,  0,  0,      0, 0);
        // containment and collision right at and just past the boundary
        add_row(4096, 0,    0,    1000, 600,    0,    400,   1, 600, 0, 360000, 1, 1);
        add_row(4096, 0,    0,    1000, 601,    0,    400,   0, 0,  0,  0,      0, 0);
        add_row(4096, 0,    0,    300,  600,    0,    300,   1, 600, 0, 360000, 1, 0);
        add_row(4096, 0,    0,    300,  0,      601,  300,   0, 0,  0,  0,      0, 0);
        add_row(4096, 5,    5,    100,  5,      5,    200,   1, 0,  0,  0,      1, 0);
        add_row(4096, 256,  256,  256,  356,    356,  0,     0, 0,  0,  0,      0, 0);
        add_row(4096, 4000, 10,   64,   50,     4090, 64,    0, 0,  0,  0,      0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (step_rows[i])
        begin
            if (step_rows[i].world != world_now)
            begin
                set_world(step_rows[i].world);
            end
            send_query(step_rows[i].q, step_rows[i].typed ? step_rows[i].res
                                       : predict_collision(step_rows[i].q, world_now));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       w = CB'($urandom_range(1, MAXC));
                1:       w = CB'(1);
                2:       w = MAXC[CB-1:0];
                3:       w = CB'($urandom_range(2, 64));
                4:       w = CB'($urandom_range(256, 65535));
                5:       w = CB'($urandom_range(1, MAXC));
                default: w = '0;
            endcase
            set_world(w);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if (n == 0)
                begin
                    // back the output up so the pipeline fills and stalls its input
                    holds_asked++;
                    burst = PRESSURE_BURST;
                end
                else
                begin
                    burst = $urandom_range(1, 40);
                end
                for (int k = 0; k < burst && n < PHASE_ITEMS; k++)
                begin
                    query_t q;
                    q = rand_query(world_now);
                    send_query(q, predict_collision(q, world_now));
                    n++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_collisions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Output side stall: random modes, plus a long hold when asked
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (holds_asked != holds_seen)
            begin
                holds_seen = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            else
            begin
                mode_left--;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    default:      out_stall <= !out_stall;
                endcase
            end
        end
    end

    // Sample between edges; a transfer completes at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_collisions.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual dir_x %0d dir_y %0d",
                         $time, dir_x, dir_y);
            end
            else
            begin
                want_res = pending_collisions.pop_front();
                check_field("dir_x", want_res.dir_x, dir_x);
                check_field("dir_y", want_res.dir_y, dir_y);
                check_field("dist_sq", want_res.dist_sq, dist_sq);
                check_field("colliding", want_res.colliding, colliding);
                check_field("contains", want_res.contains, contains);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
